>>> hdl/svrs_pkg.sv
// Package with the shared widths, codes, types and helpers of the side velocity refine stencil.
package svrs_pkg;

    // Width of every coarse value, of the running sum and of the fine value.
    localparam int VALUE_WIDTH = 32;

    // Boundary codes carried by edge_case; the unused code is handled as interior.
    localparam logic [1:0] EDGE_INTERIOR = 2'd0;
    localparam logic [1:0] EDGE_LOWER    = 2'd1;
    localparam logic [1:0] EDGE_UPPER    = 2'd2;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    // Two guard bits hold a sum or difference of four values exactly.
    typedef logic signed [VALUE_WIDTH+1:0] wide_t;
    // Signed correction, one bit wider so that its negation never overflows.
    typedef logic signed [VALUE_WIDTH:0]   corr_t;

    // One accepted input beat.
    typedef struct packed {
        logic       first_of_point;
        logic       along_odd;
        value_t     center_value;
        value_t     ahead_value;
        value_t     plus_value;
        value_t     minus_value;
        value_t     plus_ahead_value;
        value_t     minus_ahead_value;
        logic       across_odd;
        logic [1:0] edge_case;
        logic       last_of_point;
    } item_t;

    // What the gradient stage hands to the accumulator.
    typedef struct packed {
        logic   first_of_point;
        logic   last_of_point;
        value_t base;
        corr_t  corr;
    } stage_t;

    // Sign-extend a value to the guarded width.
    function automatic wide_t widen(value_t v);
        widen = {{2{v[VALUE_WIDTH-1]}}, v};
    endfunction

endpackage

>>> hdl/svrs_item_if.sv
// Channel that carries one gathered stencil item per beat.
interface svrs_item_if;
    logic                         valid;
    logic                         ready;
    logic                         first_of_point;
    logic                         along_odd;
    logic signed [svrs_pkg::VALUE_WIDTH-1:0] center_value;
    logic signed [svrs_pkg::VALUE_WIDTH-1:0] ahead_value;
    logic signed [svrs_pkg::VALUE_WIDTH-1:0] plus_value;
    logic signed [svrs_pkg::VALUE_WIDTH-1:0] minus_value;
    logic signed [svrs_pkg::VALUE_WIDTH-1:0] plus_ahead_value;
    logic signed [svrs_pkg::VALUE_WIDTH-1:0] minus_ahead_value;
    logic                         across_odd;
    logic [1:0]                   edge_case;
    logic                         last_of_point;

    modport source (
        output valid, first_of_point, along_odd, center_value, ahead_value, plus_value,
               minus_value, plus_ahead_value, minus_ahead_value, across_odd, edge_case,
               last_of_point,
        input  ready
    );

    modport sink (
        input  valid, first_of_point, along_odd, center_value, ahead_value, plus_value,
               minus_value, plus_ahead_value, minus_ahead_value, across_odd, edge_case,
               last_of_point,
        output ready
    );
endinterface

>>> hdl/svrs_result_if.sv
// Channel that carries one fine side value per beat.
interface svrs_result_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [svrs_pkg::VALUE_WIDTH-1:0] fine_value;

    modport source (
        output valid, fine_value,
        input  ready
    );

    modport sink (
        input  valid, fine_value,
        output ready
    );
endinterface

>>> hdl/svrs_grad.sv
// Gradient stage: base value and signed transverse correction, registered.
module svrs_grad (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  svrs_pkg::item_t in_data,
    output logic            in_ready,
    output logic            out_valid,
    output svrs_pkg::stage_t out_data,
    input  logic            out_ready
);

    logic              valid_reg;
    svrs_pkg::stage_t  data_reg;
    svrs_pkg::stage_t  data_next;
    svrs_pkg::wide_t   term0;
    svrs_pkg::wide_t   term1;
    svrs_pkg::wide_t   term2;
    svrs_pkg::wide_t   term3;
    svrs_pkg::wide_t   grad_sum;
    svrs_pkg::wide_t   grad_shifted;
    svrs_pkg::wide_t   mean_wide;
    svrs_pkg::corr_t   grad;
    logic              interior;

    // The stage takes a beat when it is empty or its content moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Pick the four stencil terms and the shift for the boundary case.
    always_comb
    begin
        case (in_data.edge_case)
            svrs_pkg::EDGE_LOWER:
            begin
                term0    = svrs_pkg::widen(in_data.plus_value);
                term1    = svrs_pkg::widen(in_data.plus_ahead_value);
                term2    = svrs_pkg::widen(in_data.center_value);
                term3    = svrs_pkg::widen(in_data.ahead_value);
                interior = 1'b0;
            end
            svrs_pkg::EDGE_UPPER:
            begin
                term0    = svrs_pkg::widen(in_data.center_value);
                term1    = svrs_pkg::widen(in_data.ahead_value);
                term2    = svrs_pkg::widen(in_data.minus_value);
                term3    = svrs_pkg::widen(in_data.minus_ahead_value);
                interior = 1'b0;
            end
            default:
            begin
                term0    = svrs_pkg::widen(in_data.plus_value);
                term1    = svrs_pkg::widen(in_data.plus_ahead_value);
                term2    = svrs_pkg::widen(in_data.minus_value);
                term3    = svrs_pkg::widen(in_data.minus_ahead_value);
                interior = 1'b1;
            end
        endcase

        // An even normal index uses only the terms at the center side.
        if (!in_data.along_odd)
        begin
            term1 = '0;
            term3 = '0;
        end

        // The guarded sum is exact, so the arithmetic shift is an exact floor.
        grad_sum = term0 + term1 - term2 - term3;
        case ({in_data.along_odd, interior})
            2'b00:   grad_shifted = grad_sum >>> 2;
            2'b01:   grad_shifted = grad_sum >>> 3;
            2'b10:   grad_shifted = grad_sum >>> 3;
            default: grad_shifted = grad_sum >>> 4;
        endcase
        grad = grad_shifted[svrs_pkg::VALUE_WIDTH:0];

        // Base value: the center, or the floored mean of center and ahead.
        mean_wide = (svrs_pkg::widen(in_data.center_value)
                     + svrs_pkg::widen(in_data.ahead_value)) >>> 1;

        data_next.first_of_point = in_data.first_of_point;
        data_next.last_of_point  = in_data.last_of_point;
        data_next.base           = in_data.along_odd ? mean_wide[svrs_pkg::VALUE_WIDTH-1:0]
                                                     : in_data.center_value;
        data_next.corr           = in_data.across_odd ? grad : -grad;
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> hdl/svrs_accum.sv
// Accumulator: saturating running sum and the registered result beat.
module svrs_accum (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  svrs_pkg::stage_t in_data,
    output logic             in_ready,
    output logic             result_valid,
    output svrs_pkg::value_t fine_value,
    input  logic             result_ready
);

    localparam int W = svrs_pkg::VALUE_WIDTH;

    svrs_pkg::value_t sum_reg;
    svrs_pkg::value_t sum_next;
    svrs_pkg::value_t fine_reg;
    logic             result_valid_reg;
    svrs_pkg::value_t base_sel;
    svrs_pkg::wide_t  total;
    logic             consume;

    // A beat that emits nothing never waits on the result register.
    assign in_ready     = !in_data.last_of_point || !result_valid_reg || result_ready;
    assign consume      = in_valid && in_ready;
    assign result_valid = result_valid_reg;
    assign fine_value   = fine_reg;

    // Add the correction to the base or to the held sum, then saturate.
    always_comb
    begin
        base_sel = in_data.first_of_point ? in_data.base : sum_reg;
        total    = svrs_pkg::widen(base_sel) + {in_data.corr[W], in_data.corr};
        if ((total[W+1:W-1] == 3'b000) || (total[W+1:W-1] == 3'b111))
        begin
            sum_next = total[W-1:0];
        end
        else if (total[W+1])
        begin
            sum_next = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            sum_next = {1'b0, {(W-1){1'b1}}};
        end
    end

    // Running sum, kept across points.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (consume)
        begin
            sum_reg <= sum_next;
        end
    end

    // Result valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (consume && in_data.last_of_point)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (consume && in_data.last_of_point)
        begin
            fine_reg <= sum_next;
        end
    end

endmodule

>>> hdl/side_velocity_refine_stencil.sv
// Top level of the side velocity refine stencil.
// One gathered item is accepted in every clock cycle as long as results are taken.
// An item passes an input register, the gradient stage and the saturating
// accumulator, whose result register puts the fine value of a point on the
// result channel once the beat with last_of_point is through. The running sum
// is a single register whose loop holds one add and a saturation, which sets
// the rate of one item per cycle while results are taken. The sum is kept after
// a result, so beats without first_of_point keep adding to it; it is zero after reset.
module side_velocity_refine_stencil (
    input  logic          clk,
    input  logic          rst_n,
    svrs_item_if.sink     item,
    svrs_result_if.source result
);

    logic              a_valid_reg;
    svrs_pkg::item_t   a_item_reg;
    svrs_pkg::item_t   a_item_next;
    logic              grad_ready;
    logic              b_valid;
    svrs_pkg::stage_t  b_data;
    logic              acc_ready;

    // Gather the beat's fields into one word.
    always_comb
    begin
        a_item_next.first_of_point    = item.first_of_point;
        a_item_next.along_odd         = item.along_odd;
        a_item_next.center_value      = item.center_value;
        a_item_next.ahead_value       = item.ahead_value;
        a_item_next.plus_value        = item.plus_value;
        a_item_next.minus_value       = item.minus_value;
        a_item_next.plus_ahead_value  = item.plus_ahead_value;
        a_item_next.minus_ahead_value = item.minus_ahead_value;
        a_item_next.across_odd        = item.across_odd;
        a_item_next.edge_case         = item.edge_case;
        a_item_next.last_of_point     = item.last_of_point;
    end

    assign item.ready = !a_valid_reg || grad_ready;

    // Input register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            a_valid_reg <= item.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            a_item_reg <= a_item_next;
        end
    end

    // Gradient and base value.
    svrs_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_data   (a_item_reg),
        .in_ready  (grad_ready),
        .out_valid (b_valid),
        .out_data  (b_data),
        .out_ready (acc_ready)
    );

    // Running sum and result register.
    svrs_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (b_valid),
        .in_data      (b_data),
        .in_ready     (acc_ready),
        .result_valid (result.valid),
        .fine_value   (result.fine_value),
        .result_ready (result.ready)
    );

endmodule

>>> hdl/svrs_checker.sv
// Port-level checker for the side velocity refine stencil, bound to the top level.
module svrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          item_last,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [svrs_pkg::VALUE_WIDTH-1:0] fine_value
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    // Points whose last beat went in and whose result has not been taken.
    always_comb
    begin
        pending_next = pending_reg;
        if (item_valid && item_ready && item_last)
        begin
            pending_next = pending_next + 3'd1;
        end
        if (result_valid && result_ready)
        begin
            pending_next = pending_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(fine_value))
        else $error("result beat changed while stalled");

    // No result appears without a finished point behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result beat without a finished point");

    // With the result register empty the pipeline always takes a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with an empty result register");

    // At most three finished points are in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more finished points in flight than stages");

endmodule

bind side_velocity_refine_stencil svrs_checker u_svrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_last    (item.last_of_point),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .fine_value   (result.fine_value)
);
